// File: sv/jsd_pkg.sv
`timescale 1ns / 1ps

package jsd_pkg;

    localparam int MAX_ROW_LENGTH = 4096;
    localparam int ROW_CNT_W      = $clog2(MAX_ROW_LENGTH + 1);

    localparam int LOG_W     = 21;  // Q.16 log2, integer part up to 16
    localparam int LOG_STEPS = 16;
    localparam int SQRT_W    = 44;  // sum >> 4
    localparam int SQRT_STEPS = SQRT_W / 2;
    localparam int CNT_W     = 5;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [20:0] LN_LIMIT  = 21'd1048575;
    localparam logic [15:0] DIST_MAX  = 16'hFFFF;

    typedef struct packed {
        logic load;        // latch input item
        logic check;       // row length bookkeeping
        logic log_init;    // start a log2 evaluation
        logic log_sel_s;   // operand is the pair sum, else 2*v
        logic lane_q;      // v is q, else p
        logic log_step;    // one squaring iteration
        logic save_s;      // keep log2(s)
        logic mul1;        // log difference times ln2
        logic mul2;        // round, clamp, times v
        logic acc;         // add term to sum
        logic sq_init;
        logic sq_step;
        logic finish;      // write result, clear row state
    } jsd_cmd_t;

    typedef struct packed {
        logic take;        // row not full and pair sum positive
        logic p_pos;
        logic q_pos;
        logic last;
        logic sum_neg;
    } jsd_status_t;

endpackage

// File: sv/jsd_ifs.sv
`timescale 1ns / 1ps

interface jsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] p_value;
    logic signed [15:0] q_value;
    logic               last_element;

    modport source (output valid, p_value, q_value, last_element, input ready);
    modport sink (input valid, p_value, q_value, last_element, output ready);
endinterface

interface jsd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance;
    logic        result_invalid;
    logic        saturated;

    modport source (output valid, distance, result_invalid, saturated, input ready);
    modport sink (input valid, distance, result_invalid, saturated, output ready);
endinterface

// File: sv/jensen_shannon_distance_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Moves
// pair     in   p_value, q_value (Q1.15), last_element     one column pair per item
// result   out  distance (Q2.14), result_invalid, saturated  one item per row pair
//
// Work per item depends on how many elements are positive: no term, one
// or two, each from the 16-step log2 squaring unit; a last item adds the
// square root of 22 root steps and the hand-off. One item is in work at a time.
// Reset clears the accumulator, row count and flags; no clearing pass.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only a new result waits for the register to free.

module jensen_shannon_distance_core
    import jsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jsd_in_if.sink    pair,
    jsd_out_if.source result
);

    jsd_cmd_t         cmd;
    jsd_status_t      status;
    logic [CNT_W-1:0] step_idx;

    jsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair.valid),
        .in_ready  (pair.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd),
        .step_idx  (step_idx)
    );

    jsd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .step_idx       (step_idx),
        .p_in           (pair.p_value),
        .q_in           (pair.q_value),
        .last_in        (pair.last_element),
        .status         (status),
        .distance       (result.distance),
        .result_invalid (result.result_invalid),
        .saturated      (result.saturated)
    );

endmodule

// File: sv/jsd_datapath.sv
`timescale 1ns / 1ps

module jsd_datapath
    import jsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  jsd_cmd_t           cmd,
    input  logic [CNT_W-1:0]   step_idx,
    input  logic signed [15:0] p_in,
    input  logic signed [15:0] q_in,
    input  logic               last_in,
    output jsd_status_t        status,
    output logic [15:0]        distance,
    output logic               result_invalid,
    output logic               saturated
);

    logic signed [15:0] p_reg, q_reg;
    logic signed [16:0] s_reg;
    logic               last_reg;

    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic signed [47:0]   sum_reg, sum_next;
    logic                 sat_reg, sat_next;

    logic [31:0]       y_reg;
    logic [4:0]        k_reg;
    logic [15:0]       frac_reg;
    logic [LOG_W-1:0]  ls_reg;

    logic              neg_reg;
    logic [50:0]       prod1_reg;
    logic signed [37:0] term_reg;

    logic [SQRT_W-1:0] rem_reg, res_reg, bit_reg;

    logic [15:0]        dist_reg;
    logic               inv_reg;
    logic               sat_out_reg;

    // log unit operand and leading one
    logic [16:0] log_x;
    logic [4:0]  lead;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [LOG_W-1:0]   log_val;
    logic signed [LOG_W:0] log_diff;
    logic [LOG_W-1:0]   log_mag;
    logic signed [15:0] v_sel;

    logic [51:0]        rnd;
    logic [21:0]        ln_mag;
    logic [20:0]        ln_clamp;
    logic               ln_sat;
    logic signed [21:0] ln_val;

    logic signed [48:0] sum_ext;
    logic [SQRT_W-1:0]  trial;
    logic               dist_sat;

    assign v_sel   = cmd.lane_q ? q_reg : p_reg;
    assign log_x   = cmd.log_sel_s ? s_reg[16:0] : {v_sel, 1'b0};
    assign log_val = {k_reg, frac_reg};

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (log_x[i])
                lead = 5'(i);
        end
    end

    assign sq    = 64'(y_reg) * 64'(y_reg);
    assign sq_sh = sq[63:31];

    assign log_diff = $signed({1'b0, log_val}) - $signed({1'b0, ls_reg});
    assign log_mag  = log_diff[LOG_W] ? LOG_W'(-log_diff) : log_diff[LOG_W-1:0];

    assign rnd      = {1'b0, prod1_reg} + 52'(1 << 29);
    assign ln_mag   = rnd[51:30];
    assign ln_sat   = ln_mag > {1'b0, LN_LIMIT};
    assign ln_clamp = ln_sat ? LN_LIMIT : ln_mag[20:0];
    assign ln_val   = neg_reg ? -$signed({1'b0, ln_clamp}) : $signed({1'b0, ln_clamp});

    assign sum_ext = 49'(sum_reg) + 49'(term_reg);
    assign trial   = res_reg + bit_reg;
    assign dist_sat = res_reg > SQRT_W'(DIST_MAX);

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        sum_next     = sum_reg;
        sat_next     = sat_reg;
        if (cmd.check && row_cnt_reg < ROW_CNT_W'(MAX_ROW_LENGTH))
            row_cnt_next = row_cnt_reg + 1'b1;
        if (cmd.mul2 && ln_sat)
            sat_next = 1'b1;
        if (cmd.acc)
        begin
            if (sum_ext[48] != sum_ext[47])
            begin
                sat_next = 1'b1;
                sum_next = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end
            else
            begin
                sum_next = sum_ext[47:0];
            end
        end
        if (cmd.finish)
        begin
            row_cnt_next = '0;
            sum_next     = '0;
            sat_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            sum_reg     <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            sum_reg     <= sum_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg    <= p_in;
            q_reg    <= q_in;
            s_reg    <= 17'(p_in) + 17'(q_in);
            last_reg <= last_in;
        end
        if (cmd.log_init)
        begin
            k_reg    <= lead;
            y_reg    <= 32'(log_x) << (5'd31 - lead);
            frac_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            if (sq_sh[32])
            begin
                y_reg <= sq_sh[32:1];
                frac_reg[4'(LOG_STEPS - 1) - step_idx[3:0]] <= 1'b1;
            end
            else
            begin
                y_reg <= sq_sh[31:0];
            end
        end
        if (cmd.save_s)
            ls_reg <= log_val;
        if (cmd.mul1)
        begin
            neg_reg   <= log_diff[LOG_W];
            prod1_reg <= 51'(log_mag) * 51'(LN2_Q30);
        end
        if (cmd.mul2)
            term_reg <= 38'(v_sel) * 38'(ln_val);
        if (cmd.sq_init)
        begin
            rem_reg <= SQRT_W'(sum_reg[47:4]);
            res_reg <= '0;
            bit_reg <= SQRT_W'(1) << (SQRT_W - 2);
        end
        else if (cmd.sq_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.finish)
        begin
            inv_reg <= sum_reg[47];
            if (sum_reg[47])
            begin
                dist_reg    <= '0;
                sat_out_reg <= sat_reg;
            end
            else
            begin
                dist_reg    <= dist_sat ? DIST_MAX : res_reg[15:0];
                sat_out_reg <= sat_reg | dist_sat;
            end
        end
    end

    assign status.take    = (row_cnt_reg < ROW_CNT_W'(MAX_ROW_LENGTH)) && !s_reg[16]
                            && (s_reg != '0);
    assign status.p_pos   = !p_reg[15] && (p_reg != '0);
    assign status.q_pos   = !q_reg[15] && (q_reg != '0);
    assign status.last    = last_reg;
    assign status.sum_neg = sum_reg[47];

    assign distance       = dist_reg;
    assign result_invalid = inv_reg;
    assign saturated      = sat_out_reg;

endmodule

// File: sv/jsd_ctrl.sv
`timescale 1ns / 1ps

module jsd_ctrl
    import jsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  jsd_status_t      status,
    output jsd_cmd_t         cmd,
    output logic [CNT_W-1:0] step_idx
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_LOGS   = 9'b000000100,
        ST_VINIT  = 9'b000001000,
        ST_LOGV   = 9'b000010000,
        ST_MUL1   = 9'b000100000,
        ST_MUL2   = 9'b001000000,
        ST_ACC    = 9'b010000000,
        ST_SQRT   = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             lane_reg, lane_next;
    logic             first_reg, first_next;
    logic             fin_reg, fin_next;   // waiting to hand over the result
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && !fin_reg;
    assign out_valid = out_valid_reg;
    assign step_idx = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lane_next  = lane_reg;
        first_next = first_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.lane_q = lane_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (fin_reg)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        fin_next   = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.take && (status.p_pos || status.q_pos))
                begin
                    cmd.log_init  = 1'b1;
                    cmd.log_sel_s = 1'b1;
                    lane_next     = !status.p_pos;
                    first_next    = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_LOGS;
                end
                else if (status.last)
                begin
                    cmd.sq_init = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SQRT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOGS, ST_LOGV:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LOG_STEPS - 1))
                    state_next = (state_reg == ST_LOGS) ? ST_VINIT : ST_MUL1;
            end
            ST_VINIT:
            begin
                cmd.save_s   = first_reg;
                cmd.log_init = 1'b1;
                first_next   = 1'b0;
                cnt_next     = '0;
                state_next   = ST_LOGV;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (!lane_reg && status.q_pos)
                begin
                    lane_next  = 1'b1;
                    state_next = ST_VINIT;
                end
                else if (status.last)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQRT:
            begin
                // first cycle after the last accumulate loads the root operand
                if (cnt_reg == '0 && !cmd.sq_init)
                begin
                    cmd.sq_init = 1'b1;
                    cnt_next    = CNT_W'(1);
                end
                else
                begin
                    cmd.sq_step = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS))
                    begin
                        fin_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // CHECK loads the root operand itself and jumps straight to stepping
    logic skip_init;
    assign skip_init = (state_reg == ST_CHECK) && cmd.sq_init;

    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lane_reg      <= 1'b0;
            first_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= skip_init ? CNT_W'(1) : cnt_next;
            lane_reg      <= lane_next;
            first_reg     <= first_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/jsd_checker.sv
`timescale 1ns / 1ps

module jsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] distance,
    input logic        result_invalid,
    input logic        saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(distance) && $stable(result_invalid)
            && $stable(saturated))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_invalid |-> distance == 16'd0)
        else $error("invalid result with nonzero distance");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous one still in work");

endmodule

bind jensen_shannon_distance_core jsd_checker u_jsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pair.valid),
    .in_ready       (pair.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .distance       (result.distance),
    .result_invalid (result.result_invalid),
    .saturated      (result.saturated)
);

// File: verif/jsd_tb_ifs.sv
`timescale 1ns / 1ps

// Channel interfaces come from the RTL; this file carries the bench-side helpers.
package jsd_tb_pkg;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic               last;
    } pair_item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic        invalid;
        logic        saturated;
    } dist_item_t;

endpackage

// File: verif/jensen_shannon_distance_core_tb.sv
`timescale 1ns / 1ps

module jensen_shannon_distance_core_tb;
    import jsd_pkg::*;
    import jsd_tb_pkg::*;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
    localparam int NUM_RANDOM_ROWS = 155;

    logic clk;
    logic rst_n;

    jsd_in_if  pair();
    jsd_out_if result();

    jensen_shannon_distance_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result)
    );

    // predictor state
    logic signed [47:0] div_acc;
    int unsigned        row_len;
    logic               clamp_seen;

    dist_item_t expected_q[$];
    int         errors;
    int         rows_checked;
    int         items_sent;
    bit         calm;
    bit         hold_long;

    always #10 clk = ~clk;

    function automatic longint unsigned log2_fix(longint unsigned x);
        int k;
        longint unsigned y;
        longint unsigned frac;
        k = 0;
        frac = 0;
        while (k < 63 && (x >> (k + 1)) != 0)
            k++;
        y = x << (31 - k);
        for (int i = 1; i <= 16; i++)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                frac = frac | (64'd1 << (16 - i));
            end
        end
        return longint'(k) * 65536 + frac;
    endfunction

    function automatic longint log_ratio(longint v, longint s);
        longint d;
        longint unsigned mag;
        longint r;
        d = longint'(log2_fix(2 * v)) - longint'(log2_fix(s));
        mag = (d < 0) ? -d : d;
        mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
        r = (d < 0) ? -longint'(mag) : longint'(mag);
        if (r > 1048575)
        begin
            r = 1048575;
            clamp_seen = 1'b1;
        end
        if (r < -1048575)
        begin
            r = -1048575;
            clamp_seen = 1'b1;
        end
        return r;
    endfunction

    function automatic void acc_add(longint t);
        longint n;
        n = longint'(div_acc) + t;
        if (n > longint'(ACC_MAX))
        begin
            n = ACC_MAX;
            clamp_seen = 1'b1;
        end
        if (n < longint'(ACC_MIN))
        begin
            n = ACC_MIN;
            clamp_seen = 1'b1;
        end
        div_acc = n[47:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Returns 1 and fills r when the item closes a row.
    function automatic bit predict_distance(pair_item_t it, output dist_item_t r);
        longint p;
        longint q;
        longint s;
        longint unsigned d;
        p = it.p;
        q = it.q;
        s = p + q;
        r = '0;
        if (row_len < MAX_ROW_LENGTH)
        begin
            row_len++;
            if (s > 0)
            begin
                if (p > 0)
                    acc_add(p * log_ratio(p, s));
                if (q > 0)
                    acc_add(q * log_ratio(q, s));
            end
        end
        if (!it.last)
            return 1'b0;
        if (div_acc < 0)
        begin
            r.distance = '0;
            r.invalid  = 1'b1;
        end
        else
        begin
            d = int_sqrt(longint'(div_acc) >> 4);
            if (d > 65535)
            begin
                d = 65535;
                clamp_seen = 1'b1;
            end
            r.distance = d[15:0];
            r.invalid  = 1'b0;
        end
        r.saturated = clamp_seen;
        div_acc = '0;
        row_len = 0;
        clamp_seen = 1'b0;
        return 1'b1;
    endfunction

    // valid stays up after an accept; each call drives it again with its item
    task automatic send_pair(pair_item_t it);
        dist_item_t r;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            pair.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pair.valid        <= 1'b1;
        pair.p_value      <= it.p;
        pair.q_value      <= it.q;
        pair.last_element <= it.last;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        if (predict_distance(it, r))
            expected_q.push_back(r);
        items_sent++;
    endtask

    function automatic pair_item_t rand_pair(bit last);
        pair_item_t it;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            it.p = 16'($urandom_range(0, 32767));
            it.q = 16'($urandom_range(0, 32767));
        end
        else if (mode < 8)
        begin
            it.p = 16'($urandom_range(0, 32767));
            it.q = 16'($urandom_range(0, 40));
        end
        else
        begin
            it.p = 16'($urandom);
            it.q = 16'($urandom);
        end
        it.last = last;
        return it;
    endfunction

    // Directed rows; distance is given for rows whose answer is obvious, else -1.
    typedef struct {
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic               last;
        int                 dist_known;
    } stim_row_t;

    stim_row_t directed[16] = '{
        '{16'sd0,      16'sd0,      1'b1, 0},
        '{16'sd16384,  16'sd16384,  1'b1, 0},
        '{-16'sd32768, -16'sd32768, 1'b1, 0},
        '{16'sd32767,  16'sd0,      1'b1, -1},
        '{16'sd0,      16'sd32767,  1'b1, -1},
        '{16'sd32767,  -16'sd32768, 1'b1, 0},
        '{16'sd1,      16'sd32767,  1'b0, -1},
        '{16'sd32767,  16'sd1,      1'b1, -1},
        '{16'sd100,    -16'sd50,    1'b1, -1},
        '{-16'sd1,     16'sd200,    1'b1, -1},
        '{16'sd32767,  16'sd32767,  1'b0, -1},
        '{16'sd1,      16'sd1,      1'b0, -1},
        '{16'sd20000,  16'sd3,      1'b1, -1},
        '{-16'sd1,     -16'sd1,     1'b1, 0},
        '{16'sd1,      16'sd0,      1'b1, -1},
        '{16'sd5,      16'sd32000,  1'b1, -1}
    };

    // result side: random stall plus one long hold-off
    initial
    begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
            end
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                gap = $urandom_range(1, 11);
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        dist_item_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result distance=%0d invalid=%0b sat=%0b",
                         $time, result.distance, result.result_invalid, result.saturated);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                rows_checked++;
                if (result.distance !== want.distance)
                begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, result.distance);
                    errors++;
                end
                if (result.result_invalid !== want.invalid)
                begin
                    $display("%0t: result_invalid expected %0b actual %0b",
                             $time, want.invalid, result.result_invalid);
                    errors++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.saturated, result.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        pair_item_t it;
        int len;
        int prev_size;
        clk = 1'b0;
        rst_n = 1'b0;
        pair.valid = 1'b0;
        pair.p_value = '0;
        pair.q_value = '0;
        pair.last_element = 1'b0;
        div_acc = '0;
        row_len = 0;
        clamp_seen = 1'b0;
        errors = 0;
        rows_checked = 0;
        items_sent = 0;
        calm = 1'b0;
        hold_long = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            it.p = directed[i].p;
            it.q = directed[i].q;
            it.last = directed[i].last;
            prev_size = expected_q.size();
            send_pair(it);
            if (directed[i].dist_known >= 0 && expected_q.size() > prev_size
                && expected_q[$].distance != directed[i].dist_known[15:0])
            begin
                $display("%0t: predictor table row %0d expected %0d actual %0d",
                         $time, i, directed[i].dist_known, expected_q[$].distance);
                errors++;
            end
        end

        // receiver holds off while short rows keep coming
        hold_long = 1'b1;
        for (int j = 0; j < 30; j++)
            send_pair(rand_pair(1'b1));

        // sender waits for everything outstanding
        pair.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);

        for (int r = 0; r < NUM_RANDOM_ROWS; r++)
        begin
            if (r == NUM_RANDOM_ROWS - 15)
                calm = 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
            for (int j = 0; j < len; j++)
            begin
                it = rand_pair(j == len - 1);
                if ($urandom_range(0, 30) == 0)
                    it.last = 1'b1;
                send_pair(it);
            end
        end

        pair.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d pair items, checked %0d row distances", items_sent, rows_checked);
        $display("Covered negative and zero sums, one-sided terms and long output stalls");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/jsd_pkg.sv
sv/jsd_ifs.sv
sv/jsd_datapath.sv
sv/jsd_ctrl.sv
sv/jensen_shannon_distance_core.sv
sv/jsd_checker.sv
verif/jsd_tb_ifs.sv
verif/jensen_shannon_distance_core_tb.sv
